FILE: design/swm_pkg.sv
// Shared constants, codes and types of the star wildcard matcher.
`default_nettype none
package swm_pkg;

	localparam int PATTERN_DEPTH = 64;
	localparam int TEXT_DEPTH    = 256;

	localparam int PAT_ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int TXT_ADDR_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int PAT_LEN_W  = $clog2(PATTERN_DEPTH + 1);
	localparam int TXT_LEN_W  = $clog2(TEXT_DEPTH + 1);

	localparam logic [7:0] STAR_BYTE = 8'h2A;

	localparam logic [1:0] MODE_PATTERN = 2'd0;
	localparam logic [1:0] MODE_TEXT    = 2'd1;
	localparam logic [1:0] MODE_EVAL    = 2'd2;

	typedef struct packed {
		logic idle;
		logic done;
		logic matched;
		logic overflowed;
	} swm_status_t;

endpackage
`default_nettype wire

FILE: design/swm_engine.sv
// Pattern and text stores with the sequencer that walks them through one byte comparator.
`default_nettype none
module swm_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           mode,
	input  wire logic [7:0]           byte_value,
	input  wire logic                 take,
	output swm_pkg::swm_status_t      status
);

	localparam int PLW = swm_pkg::PAT_LEN_W;
	localparam int TLW = swm_pkg::TXT_LEN_W;
	localparam int PAW = swm_pkg::PAT_ADDR_W;
	localparam int TAW = swm_pkg::TXT_ADDR_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [7:0] pat_mem [swm_pkg::PATTERN_DEPTH];
	logic [7:0] txt_mem [swm_pkg::TEXT_DEPTH];

	logic [1:0]     state_q;
	logic [PLW-1:0] plen_q, pi_q, star_q;
	logic [TLW-1:0] tlen_q, ti_q, resume_q;
	logic           ovf_q, have_star_q, match_q;
	logic [7:0]     p_rd_q, t_rd_q;

	logic load_ok, p_room, t_room, p_we, t_we;
	logic p_ok, t_ok, p_star, bytes_eq;

	assign load_ok = start && (state_q == ST_IDLE);
	assign p_room  = plen_q < PLW'(swm_pkg::PATTERN_DEPTH);
	assign t_room  = tlen_q < TLW'(swm_pkg::TEXT_DEPTH);
	assign p_we    = load_ok && (mode == swm_pkg::MODE_PATTERN) && p_room;
	assign t_we    = load_ok && (mode == swm_pkg::MODE_TEXT) && t_room;

	// The shared compare unit: one pattern byte against the star and the text byte.
	assign p_ok     = pi_q < plen_q;
	assign t_ok     = ti_q < tlen_q;
	assign p_star   = p_rd_q == swm_pkg::STAR_BYTE;
	assign bytes_eq = p_rd_q == t_rd_q;

	always_ff @(posedge clk) begin
		if (p_we) begin
			pat_mem[plen_q[PAW-1:0]] <= byte_value;
		end
		if (t_we) begin
			txt_mem[tlen_q[TAW-1:0]] <= byte_value;
		end
		p_rd_q <= pat_mem[pi_q[PAW-1:0]];
		t_rd_q <= txt_mem[ti_q[TAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plen_q      <= '0;
			tlen_q      <= '0;
			ovf_q       <= 1'b0;
			pi_q        <= '0;
			ti_q        <= '0;
			star_q      <= '0;
			resume_q    <= '0;
			have_star_q <= 1'b0;
			match_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (mode)
							swm_pkg::MODE_PATTERN: begin
								if (p_room) begin
									plen_q <= plen_q + PLW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							swm_pkg::MODE_TEXT: begin
								if (t_room) begin
									tlen_q <= tlen_q + TLW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							swm_pkg::MODE_EVAL: begin
								pi_q        <= '0;
								ti_q        <= '0;
								resume_q    <= '0;
								have_star_q <= 1'b0;
								match_q     <= 1'b0;
								state_q     <= ovf_q ? ST_DONE : ST_FETCH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (t_ok) begin
						if (p_ok && p_star) begin
							have_star_q <= 1'b1;
							star_q      <= pi_q;
							pi_q        <= pi_q + PLW'(1);
							resume_q    <= ti_q;
							state_q     <= ST_FETCH;
						end else if (p_ok && bytes_eq) begin
							pi_q    <= pi_q + PLW'(1);
							ti_q    <= ti_q + TLW'(1);
							state_q <= ST_FETCH;
						end else if (have_star_q) begin
							// Let the last star swallow one more text byte and retry.
							pi_q     <= star_q + PLW'(1);
							resume_q <= resume_q + TLW'(1);
							ti_q     <= resume_q + TLW'(1);
							state_q  <= ST_FETCH;
						end else begin
							match_q <= 1'b0;
							state_q <= ST_DONE;
						end
					end else begin
						// Text used up: only trailing stars may remain in the pattern.
						if (p_ok && p_star) begin
							pi_q    <= pi_q + PLW'(1);
							state_q <= ST_FETCH;
						end else begin
							match_q <= pi_q == plen_q;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (take) begin
						plen_q  <= '0;
						tlen_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.idle       = state_q == ST_IDLE;
	assign status.done       = state_q == ST_DONE;
	assign status.matched    = match_q;
	assign status.overflowed = ovf_q;

endmodule
`default_nettype wire

FILE: design/star_wildcard_matcher_core.sv
// Top level of the star wildcard matcher: input handshake, engine and result register.
//
//   channel   direction   handshake             payload
//   request   in          in_valid / in_ready   mode, byte_value
//   result    out         out_valid / out_ready matched, overflowed
//
// A pattern or text byte is written into its store at the handshake. An evaluate request
// runs S match steps, where each step reads both stores in the fetch state and then
// uses the shared byte comparator in the compare state. After an overflow it skips the steps.
// The engine holds in_ready low from an evaluate until its result enters the output
// register; a stalled result delays only the next evaluate's completion.
// Reset empties both stores and clears the overflow flag; no clearing pass is needed.
`default_nettype none
module star_wildcard_matcher_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] byte_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            matched,
	output logic            overflowed
);

	swm_pkg::swm_status_t status;
	logic                 take;
	logic                 out_valid_q, matched_q, overflowed_q;

	assign in_ready = status.idle;
	assign take     = !out_valid_q || out_ready;

	swm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && in_ready),
		.mode       (mode),
		.byte_value (byte_value),
		.take       (take),
		.status     (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.done && take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done && take) begin
			matched_q    <= status.matched && !status.overflowed;
			overflowed_q <= status.overflowed;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign overflowed = overflowed_q;

endmodule
`default_nettype wire

FILE: design/swm_checker.sv
// Port-level checks of the star wildcard matcher and their binding to the top level.
`default_nettype none
module swm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] mode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       matched,
	input wire logic       overflowed
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(overflowed))
		else $error("stalled result changed");

	a_overflow_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && overflowed))
		else $error("result shows a match together with an overflow");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == swm_pkg::MODE_EVAL |=> !in_ready)
		else $error("ready right after an evaluate request");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode != swm_pkg::MODE_EVAL |=> in_ready)
		else $error("a byte request did not complete in one cycle");

endmodule

bind star_wildcard_matcher_core swm_checker u_swm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.mode       (mode),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.matched    (matched),
	.overflowed (overflowed)
);
`default_nettype wire
